// ----- rtl/core/cpq_pkg.sv -----
// Shared types and constants for the charger presence qualifier.
// Used by cpq_tick and charger_presence_qualifier; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cpq_pkg;

  localparam int unsigned THR_W = 10;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned VOLT_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = THR_W;

  localparam logic [THR_W-1:0] CP_LOW_RST = THR_W'(100);
  localparam logic [THR_W-1:0] CB_LOW_RST = THR_W'(100);
  localparam logic [THR_W-1:0] CP_HIGH_RST = THR_W'(900);
  localparam logic [THR_W-1:0] CB_HIGH_RST = THR_W'(900);
  localparam logic [CNT_W-1:0] CHECK_PERIOD_RST = CNT_W'(10);
  localparam logic [CNT_W-1:0] ON_CONFIRM_RST = CNT_W'(5);
  localparam logic [CNT_W-1:0] OVER_CONFIRM_RST = CNT_W'(6);
  localparam logic [CNT_W-1:0] TRIGGER_DELAY_RST = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CP_LOW        = 3'd0,
    REG_CB_LOW        = 3'd1,
    REG_CP_HIGH       = 3'd2,
    REG_CB_HIGH       = 3'd3,
    REG_CHECK_PERIOD  = 3'd4,
    REG_ON_CONFIRM    = 3'd5,
    REG_OVER_CONFIRM  = 3'd6,
    REG_TRIGGER_DELAY = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] cp_low_threshold;
    logic [THR_W-1:0] cb_low_threshold;
    logic [THR_W-1:0] cp_high_threshold;
    logic [THR_W-1:0] cb_high_threshold;
    logic [CNT_W-1:0] check_period;
    logic [CNT_W-1:0] on_confirm;
    logic [CNT_W-1:0] over_confirm;
    logic [CNT_W-1:0] trigger_delay;
  } cfg_t;

  typedef struct packed {
    logic              charging_current;
    logic [THR_W-1:0]  sample_cp;
    logic [THR_W-1:0]  sample_cb;
    logic [VOLT_W-1:0] charger_voltage;
    logic [VOLT_W-1:0] battery_voltage;
    logic              trigger_edge;
    logic              discharge_stop;
    logic              clear_fault;
  } tick_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] ticks_since_check;
    logic [CNT_W-1:0] on_count;
    logic [CNT_W-1:0] over_count;
    logic [CNT_W-1:0] trigger_ticks;
    logic             present_flag;
    logic             checking_flag;
    logic             fault_flag;
    logic             discharge_flag;
    logic             pending_flag;
    logic             armed_flag;
  } qual_state_t;

  typedef struct packed {
    logic charger_present;
    logic checking;
    logic overvoltage_fault;
    logic discharge_enable;
    logic trigger_pending;
    logic trigger_armed;
    logic comm_restart;
    logic led_normal;
  } tick_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpq_tick.sv -----
// Next-state and result logic for one tick of the charger presence qualifier.
// Pure combinational; depends on cpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpq_tick
  import cpq_pkg::*;
(
  input  var cfg_t        cfg,
  input  var qual_state_t cur,
  input  var tick_in_t    tin,
  output qual_state_t     nxt,
  output tick_out_t       res
);

  logic [CNT_W:0] ticks_inc;
  logic           above_low;
  logic           above_high;
  logic           restart;
  logic           led;

  assign ticks_inc  = {1'b0, cur.ticks_since_check} + (CNT_W+1)'(1);
  assign above_low  = (tin.sample_cp > cfg.cp_low_threshold) ||
                      (tin.sample_cb > cfg.cb_low_threshold);
  assign above_high = (tin.sample_cp > cfg.cp_high_threshold) ||
                      (tin.sample_cb > cfg.cb_high_threshold);

  always_comb begin
    nxt     = cur;
    restart = 1'b0;
    led     = 1'b0;

    // tick-start requests
    if (tin.discharge_stop) nxt.discharge_flag = 1'b0;
    if (tin.clear_fault)    nxt.fault_flag     = 1'b0;
    if (tin.trigger_edge && cur.armed_flag) begin
      nxt.pending_flag  = 1'b1;
      nxt.armed_flag    = 1'b0;
      nxt.trigger_ticks = '0;
    end

    // presence check
    if (ticks_inc >= {1'b0, cfg.check_period}) begin
      nxt.ticks_since_check = '0;
      if (tin.charging_current) begin
        nxt.present_flag  = 1'b1;
        nxt.checking_flag = 1'b0;
      end else if (above_low) begin
        nxt.checking_flag = !cur.present_flag;
        if (cur.on_count != CNT_MAX) nxt.on_count = cur.on_count + CNT_W'(1);
        if (nxt.on_count > cfg.on_confirm) begin
          nxt.on_count = '0;
          if (!cur.present_flag) begin
            if (above_high) begin
              if (cur.over_count != CNT_MAX) nxt.over_count = cur.over_count + CNT_W'(1);
              if (nxt.over_count >= cfg.over_confirm) begin
                nxt.over_count    = '0;
                nxt.present_flag  = 1'b1;
                nxt.fault_flag    = 1'b1;
                nxt.checking_flag = 1'b0;
              end
            end else begin
              nxt.over_count     = '0;
              nxt.present_flag   = 1'b1;
              nxt.checking_flag  = 1'b0;
              nxt.discharge_flag = 1'b1;
              nxt.armed_flag     = 1'b0;
              restart            = 1'b1;
              led                = 1'b1;
            end
          end
        end
      end else begin
        nxt.checking_flag = 1'b0;
        nxt.on_count      = '0;
        nxt.over_count    = '0;
        if ((tin.sample_cp < cfg.cp_low_threshold) &&
            (tin.charger_voltage < tin.battery_voltage)) begin
          nxt.present_flag = 1'b0;
        end
      end
    end else begin
      nxt.ticks_since_check = ticks_inc[CNT_W-1:0];
    end

    // trigger delay
    if (nxt.pending_flag) begin
      if (nxt.trigger_ticks >= cfg.trigger_delay) begin
        nxt.trigger_ticks  = '0;
        nxt.pending_flag   = 1'b0;
        nxt.discharge_flag = 1'b1;
        restart            = 1'b1;
      end else begin
        nxt.trigger_ticks = nxt.trigger_ticks + CNT_W'(1);
      end
    end else begin
      nxt.trigger_ticks = '0;
    end

    // rearm when everything is idle
    if (!nxt.present_flag && !nxt.discharge_flag && !nxt.pending_flag) begin
      nxt.armed_flag = 1'b1;
    end

    res.charger_present   = nxt.present_flag;
    res.checking          = nxt.checking_flag;
    res.overvoltage_fault = nxt.fault_flag;
    res.discharge_enable  = nxt.discharge_flag;
    res.trigger_pending   = nxt.pending_flag;
    res.trigger_armed     = nxt.armed_flag;
    res.comm_restart      = restart;
    res.led_normal        = led;
  end

endmodule

`default_nettype wire

// ----- rtl/core/charger_presence_qualifier.sv -----
// Charger presence qualifier top level: channels, config registers, state.
// Depends on cpq_pkg and cpq_tick.
//
// Usage:
//   Each input item is one 10 ms tick carrying the charger-path samples,
//   the charger and battery voltages and the tick-start requests. Each
//   tick produces exactly one result item with the flags after that tick.
//   Both channels move an item on a rising edge with valid high and stall
//   low. Items enter an input register, are evaluated combinationally
//   against the state registers and land in the result register.
//   Throughput: 1 item per cycle while out_stall is low; a new item is
//   taken while the previous result waits, since the input and result
//   registers form two stages.
//   When the receiver stalls, the result holds; the input register then
//   fills and in_stall rises until the result is taken.
//   Reset (rst_n low, synchronous): configuration returns to its defaults,
//   counters clear, discharge enable is set, both stages empty.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect on the
//   next edge; write only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module charger_presence_qualifier
  import cpq_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  // configuration
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  // tick items in
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   in_charging_current,
  input  wire [THR_W-1:0]       in_sample_cp,
  input  wire [THR_W-1:0]       in_sample_cb,
  input  wire [VOLT_W-1:0]      in_charger_voltage,
  input  wire [VOLT_W-1:0]      in_battery_voltage,
  input  wire                   in_trigger_edge,
  input  wire                   in_discharge_stop,
  input  wire                   in_clear_fault,
  // result items out
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  out_charger_present,
  output logic                  out_checking,
  output logic                  out_overvoltage_fault,
  output logic                  out_discharge_enable,
  output logic                  out_trigger_pending,
  output logic                  out_trigger_armed,
  output logic                  out_comm_restart,
  output logic                  out_led_normal
);

  // state after reset: everything clear except discharge enable
  localparam qual_state_t STATE_RST = '{discharge_flag: 1'b1, default: '0};

  cfg_t        cfg_r;
  qual_state_t state_r;
  qual_state_t state_nxt;
  tick_in_t    in_data_r;
  tick_in_t    in_data;
  logic        in_valid_r;
  tick_out_t   res_r;
  tick_out_t   res_nxt;
  logic        out_valid_r;

  logic out_free;   // result register can take a new item this cycle
  logic fire;       // evaluate the held tick item
  logic in_free;    // input register can take a new item this cycle

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_free  = !in_valid_r || fire;
  assign in_stall = !in_free;

  assign in_data = '{
    charging_current: in_charging_current,
    sample_cp:        in_sample_cp,
    sample_cb:        in_sample_cb,
    charger_voltage:  in_charger_voltage,
    battery_voltage:  in_battery_voltage,
    trigger_edge:     in_trigger_edge,
    discharge_stop:   in_discharge_stop,
    clear_fault:      in_clear_fault
  };

  // one tick of qualification logic
  cpq_tick u_tick (
    .cfg (cfg_r),
    .cur (state_r),
    .tin (in_data_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cp_low_threshold  <= CP_LOW_RST;
      cfg_r.cb_low_threshold  <= CB_LOW_RST;
      cfg_r.cp_high_threshold <= CP_HIGH_RST;
      cfg_r.cb_high_threshold <= CB_HIGH_RST;
      cfg_r.check_period      <= CHECK_PERIOD_RST;
      cfg_r.on_confirm        <= ON_CONFIRM_RST;
      cfg_r.over_confirm      <= OVER_CONFIRM_RST;
      cfg_r.trigger_delay     <= TRIGGER_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_CP_LOW:        cfg_r.cp_low_threshold  <= cfg_wdata;
        REG_CB_LOW:        cfg_r.cb_low_threshold  <= cfg_wdata;
        REG_CP_HIGH:       cfg_r.cp_high_threshold <= cfg_wdata;
        REG_CB_HIGH:       cfg_r.cb_high_threshold <= cfg_wdata;
        REG_CHECK_PERIOD:  cfg_r.check_period      <= cfg_wdata[CNT_W-1:0];
        REG_ON_CONFIRM:    cfg_r.on_confirm        <= cfg_wdata[CNT_W-1:0];
        REG_OVER_CONFIRM:  cfg_r.over_confirm      <= cfg_wdata[CNT_W-1:0];
        REG_TRIGGER_DELAY: cfg_r.trigger_delay     <= cfg_wdata[CNT_W-1:0];
        default:           cfg_r                   <= cfg_r;
      endcase
    end
  end

  // qualifier state: advance only when a tick is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // input stage: take a new item whenever the register is empty or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_free) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // result stage: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_charger_present   = res_r.charger_present;
  assign out_checking          = res_r.checking;
  assign out_overvoltage_fault = res_r.overvoltage_fault;
  assign out_discharge_enable  = res_r.discharge_enable;
  assign out_trigger_pending   = res_r.trigger_pending;
  assign out_trigger_armed     = res_r.trigger_armed;
  assign out_comm_restart      = res_r.comm_restart;
  assign out_led_normal        = res_r.led_normal;

endmodule

`default_nettype wire
